// File: rtl/wav_header_validator_macros.svh
// Assertion macros used by the wav_header_validator checker.
`ifndef WAV_HEADER_VALIDATOR_MACROS_SVH
`define WAV_HEADER_VALIDATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WAVHV_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wav_header_validator: port check failed");

// Consequent must hold in the cycle after the antecedent.
`define WAVHV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wav_header_validator: port check failed");

`endif

// File: rtl/wavhv_pkg.sv
// Types and constants shared by the WAV header validator modules.
package wavhv_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_RF64 = 32'h3436_4652;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DS64 = 32'h3436_7364;

  localparam logic [15:0] FMT_PCM        = 16'h0001;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hfffe;
  localparam logic [31:0] GUID_WORD0     = 32'h0000_0001;
  localparam logic [31:0] GUID_WORD1     = 32'h0010_0000;
  localparam logic [31:0] GUID_WORD2     = 32'haa00_0080;
  localparam logic [31:0] GUID_WORD3     = 32'h719b_3800;

  localparam logic [40:0] LEN_LIMIT       = 41'h100_0000_0000;
  localparam logic [40:0] LEN_MIN         = 41'd44;
  localparam logic [31:0] MAX_CHUNK_BYTES = 32'd16777216;
  localparam logic [15:0] MAX_CHANNELS    = 16'd64;
  localparam logic [31:0] RATE_MIN        = 32'd8000;
  localparam logic [31:0] RATE_MAX        = 32'd384000;
  localparam logic [31:0] DATA_SIZE_RF64  = 32'hffff_ffff;

  localparam int unsigned OUT_W = 120;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_NOT_WAVE  = 4'd2,
    ST_NO_FMT    = 4'd3,
    ST_BOUNDS    = 4'd4,
    ST_BAD_FMT   = 4'd5,
    ST_BAD_EXT   = 4'd6,
    ST_NOT_PCM16 = 4'd7,
    ST_MISMATCH  = 4'd8,
    ST_BAD_RF64  = 4'd9,
    ST_NO_FRAMES = 4'd10,
    ST_NO_DATA   = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    CFG_FILE_LENGTH = 2'd0,
    CFG_CHANNELS    = 2'd1,
    CFG_RATE        = 2'd2,
    CFG_FINALIZED   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic    start;
    logic    head_byte;
    logic    hdr_byte;
    logic    hdr_init;
    logic    hchk;
    logic    body_byte;
    logic    fchk;
    logic    cnt_inc;
    logic    avail;
    logic    fin;
    logic    load_out;
    logic    out_full;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic    len_bad;
    logic    head_last;
    logic    riff_ok;
    logic    hdr_last;
    logic    is_data;
    logic    format_seen;
    logic    bounds_bad;
    logic    fmt_dup;
    logic    size_zero;
    logic    fchk_now;
    logic    ds64_bad;
    logic    body_end;
    logic    end_pending;
    logic    fmt_fail;
    status_t fmt_code;
    logic    bound_bad;
    logic    div_done;
    logic    frames_zero;
  } dp_stat_t;

endpackage

// File: rtl/wav_header_validator.sv
// WAV header validator: streams a file byte by byte from offset zero (byte in s_tdata,
// start-of-file flag in s_tuser, which restarts the parse when accepted) and returns one
// result per file on the master side. It checks a RIFF or RF64 container with the WAVE
// tag, walks up to MAX_CHUNKS chunks with even padding, checks the fmt chunk for 16-bit
// PCM (plain or extensible with the PCM subformat) against the journal channel count
// and rate, reads the 64-bit data size from ds64, and at the data chunk reports data
// offset, whole frames, tail bytes and a stale-size flag; an error other than no frames
// gives a status code with the other fields zero. Bytes before a start-of-file byte or
// after a result are dropped. Throughput: one byte per cycle inside a chunk header or
// body, with a stall after each chunk header, each chunk end and each of the one or two
// fmt checks; the result then waits on the bit-serial divider (40 steps) that splits
// usable bytes into frames. Configuration is written through cfg_we/cfg_index/
// cfg_data (0 file length, 1 journal channels, 2 journal rate, 3 finalized).
module wav_header_validator
  import wavhv_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [40:0]      cfg_data,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] byte_value
  input  logic             s_tuser,   // [0] start_of_file
  output logic             m_tvalid,
  input  logic             m_tready,
  // [3:0] status, [44:4] data_offset, [84:45] frames, [91:85] ignored_tail,
  // [92] stale_header, [99:93] channel_count, [118:100] sample_rate, [119] zero
  output logic [OUT_W-1:0] m_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing: which byte phase we are in and when to stall for checks.
  wavhv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .sof       (s_tuser),
    .stat      (stat),
    .out_ready (m_tready),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  // Field capture, bound checks, frame division and the result register.
  wavhv_dp #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_value (s_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .result     (m_tdata)
  );

endmodule

// File: rtl/wavhv_div.sv
// Restoring divider, one quotient bit per cycle: byte pairs over channel count.
module wavhv_div
  import wavhv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [8:0]  divisor,
  output logic        done,
  output logic [39:0] quotient,
  output logic [8:0]  remainder
);

  localparam logic [5:0] STEPS = 6'd40;

  logic       busy;
  logic [5:0] cnt;
  logic [9:0] trial;
  logic       ge;

  assign trial = {remainder, quotient[39]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      done      <= 1'b0;
      cnt       <= STEPS;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[38:0], ge};
      remainder <= ge ? 9'(trial - {1'b0, divisor}) : trial[8:0];
      cnt       <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/wavhv_dp.sv
// Datapath: configuration, byte position, chunk fields, fmt capture and result.
module wavhv_dp
  import wavhv_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [40:0]      cfg_data,
  input  logic [7:0]       byte_value,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic [OUT_W-1:0] result
);

  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);

  logic [40:0]      file_length;
  logic [6:0]       journal_channels;
  logic [18:0]      journal_rate;
  logic             finalized;

  logic [40:0]      pos;
  logic [CNT_W-1:0] chunk_count;
  logic [31:0]      chunk_tag;
  logic [31:0]      chunk_size;
  logic [40:0]      chunk_begin;
  logic [2:0]       hdr_idx;
  logic [5:0]       rel;
  logic [32:0]      remain;
  logic             end_pending;
  logic             fchk_ext;
  logic             format_seen;
  logic [319:0]     fmt_bytes;
  logic [63:0]      rf64_size;
  logic [8:0]       ch_r;
  logic [18:0]      rate_r;
  logic [40:0]      avail;
  logic             stale;
  logic             bit0;

  logic [15:0] f_tag, f_ch, f_align, f_bits, f_cb, f_vbits;
  logic [31:0] f_rate, f_brate, f_g0, f_g1, f_g2, f_g3;
  logic [26:0] prod;
  logic        common_ok;
  logic        fmt_pass;
  logic        fmt_cap;
  logic        ds64_cap;
  logic [63:0] declared;
  logic [40:0] usable;
  logic        div_done;
  logic [39:0] quo;
  logic [8:0]  rem;
  logic [9:0]  tail_full;

  assign f_tag   = fmt_bytes[15:0];
  assign f_ch    = fmt_bytes[31:16];
  assign f_rate  = fmt_bytes[63:32];
  assign f_brate = fmt_bytes[95:64];
  assign f_align = fmt_bytes[111:96];
  assign f_bits  = fmt_bytes[127:112];
  assign f_cb    = fmt_bytes[143:128];
  assign f_vbits = fmt_bytes[159:144];
  assign f_g0    = fmt_bytes[223:192];
  assign f_g1    = fmt_bytes[255:224];
  assign f_g2    = fmt_bytes[287:256];
  assign f_g3    = fmt_bytes[319:288];

  // Byte rate only needs the narrow product: any wider align fails the align test.
  assign prod = f_rate[18:0] * f_align[7:0];

  assign common_ok = (f_bits == 16'd16) && (f_ch >= 16'd1) && (f_ch <= MAX_CHANNELS)
                     && (f_rate >= RATE_MIN) && (f_rate <= RATE_MAX)
                     && ({1'b0, f_align} == {f_ch, 1'b0})
                     && (f_brate == {5'd0, prod})
                     && (f_ch == {9'd0, journal_channels})
                     && (f_rate == {13'd0, journal_rate});

  always_comb begin
    stat.fmt_fail = 1'b0;
    stat.fmt_code = ST_OK;
    fmt_pass      = 1'b0;
    if (fchk_ext) begin
      if (f_cb < 16'd22 || f_cb >= 16'h8000) begin
        stat.fmt_fail = 1'b1;
        stat.fmt_code = ST_BAD_EXT;
      end else if (f_vbits != 16'd16 || f_g0 != GUID_WORD0 || f_g1 != GUID_WORD1
                   || f_g2 != GUID_WORD2 || f_g3 != GUID_WORD3) begin
        stat.fmt_fail = 1'b1;
        stat.fmt_code = ST_NOT_PCM16;
      end else if (!common_ok) begin
        stat.fmt_fail = 1'b1;
        stat.fmt_code = ST_MISMATCH;
      end else begin
        fmt_pass = 1'b1;
      end
    end else if (f_tag == FMT_EXTENSIBLE) begin
      if (chunk_size < 32'd40) begin
        stat.fmt_fail = 1'b1;
        stat.fmt_code = ST_BAD_EXT;
      end
    end else if (f_tag != FMT_PCM) begin
      stat.fmt_fail = 1'b1;
      stat.fmt_code = ST_NOT_PCM16;
    end else if (!common_ok) begin
      stat.fmt_fail = 1'b1;
      stat.fmt_code = ST_MISMATCH;
    end else begin
      fmt_pass = 1'b1;
    end
  end

  assign fmt_cap  = (chunk_tag == TAG_FMT) && !format_seen && (rel < 6'd40);
  assign ds64_cap = (chunk_tag == TAG_DS64) && (chunk_size >= 32'd28)
                    && (rel >= 6'd8) && (rel < 6'd16);

  assign declared = (chunk_size == DATA_SIZE_RF64) ? rf64_size : {32'd0, chunk_size};
  assign usable   = (finalized && (declared < {23'd0, avail})) ? declared[40:0] : avail;

  assign stat.len_bad     = (file_length > LEN_LIMIT) || (file_length < LEN_MIN);
  assign stat.head_last   = pos == 41'd11;
  assign stat.riff_ok     = ((chunk_tag == TAG_RIFF) || (chunk_tag == TAG_RF64))
                            && (chunk_size == TAG_WAVE);
  assign stat.hdr_last    = hdr_idx == 3'd7;
  assign stat.is_data     = chunk_tag == TAG_DATA;
  assign stat.format_seen = format_seen;
  assign stat.bounds_bad  = (chunk_size > MAX_CHUNK_BYTES)
                            || (({1'b0, pos} + {10'd0, chunk_size}) > {1'b0, file_length});
  assign stat.fmt_dup     = (chunk_tag == TAG_FMT) && (format_seen || chunk_size < 32'd16);
  assign stat.size_zero   = chunk_size == 32'd0;
  assign stat.fchk_now    = fmt_cap && (rel == 6'd15 || rel == 6'd39);
  assign stat.ds64_bad    = ds64_cap && (rel == 6'd15) && byte_value[7];
  assign stat.body_end    = remain == 33'd1;
  assign stat.end_pending = end_pending;
  assign stat.bound_bad   = (chunk_count >= CNT_W'(MAX_CHUNKS))
                            || (({1'b0, pos} + 42'd8) > {1'b0, file_length});
  assign stat.div_done    = div_done;
  assign stat.frames_zero = quo == 40'd0;

  assign tail_full = {rem, bit0};

  wavhv_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.fin),
    .dividend  (usable[40:1]),
    .divisor   (ch_r),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length      <= '0;
      journal_channels <= '0;
      journal_rate     <= '0;
      finalized        <= 1'b0;
      pos              <= '0;
      chunk_count      <= '0;
      chunk_tag        <= '0;
      chunk_size       <= '0;
      chunk_begin      <= '0;
      hdr_idx          <= '0;
      rel              <= '0;
      remain           <= '0;
      end_pending      <= 1'b0;
      fchk_ext         <= 1'b0;
      format_seen      <= 1'b0;
      rf64_size        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FILE_LENGTH: file_length      <= cfg_data;
          CFG_CHANNELS:    journal_channels <= cfg_data[6:0];
          CFG_RATE:        journal_rate     <= cfg_data[18:0];
          CFG_FINALIZED:   finalized        <= cfg_data[0];
          default:         finalized        <= finalized;
        endcase
      end

      if (cmd.start) begin
        pos         <= 41'd1;
        chunk_tag   <= {24'd0, byte_value};
        chunk_size  <= '0;
        chunk_count <= '0;
        format_seen <= 1'b0;
        rf64_size   <= '0;
        hdr_idx     <= '0;
      end

      if (cmd.head_byte) begin
        pos <= pos + 41'd1;
        if (pos < 41'd4) begin
          chunk_tag[{pos[1:0], 3'b000} +: 8] <= byte_value;
        end else if (pos >= 41'd8 && pos < 41'd12) begin
          chunk_size[{pos[1:0], 3'b000} +: 8] <= byte_value;
        end
      end

      if (cmd.hdr_byte) begin
        pos     <= pos + 41'd1;
        hdr_idx <= hdr_idx + 3'd1;
        if (!hdr_idx[2]) begin
          chunk_tag[{hdr_idx[1:0], 3'b000} +: 8] <= byte_value;
        end else begin
          chunk_size[{hdr_idx[1:0], 3'b000} +: 8] <= byte_value;
        end
      end

      if (cmd.hdr_init) begin
        hdr_idx <= '0;
      end

      if (cmd.hchk) begin
        chunk_begin <= pos;
        rel         <= '0;
        remain      <= {1'b0, chunk_size} + {32'd0, chunk_size[0]};
      end

      if (cmd.body_byte) begin
        pos         <= pos + 41'd1;
        remain      <= remain - 33'd1;
        end_pending <= remain == 33'd1;
        fchk_ext    <= rel == 6'd39;
        if (rel != 6'd63) begin
          rel <= rel + 6'd1;
        end
        if (fmt_cap) begin
          for (int i = 0; i < 40; i++) begin
            if (rel == 6'(i)) begin
              fmt_bytes[8*i +: 8] <= byte_value;
            end
          end
        end
        if (ds64_cap) begin
          rf64_size[{rel[2:0], 3'b000} +: 8] <= byte_value;
        end
      end

      if (cmd.fchk && fmt_pass) begin
        format_seen <= 1'b1;
        ch_r        <= f_ch[8:0];
        rate_r      <= f_rate[18:0];
      end

      if (cmd.cnt_inc) begin
        chunk_count <= chunk_count + CNT_W'(1);
      end

      if (cmd.avail) begin
        avail <= (file_length > chunk_begin) ? file_length - chunk_begin : 41'd0;
      end

      if (cmd.fin) begin
        stale <= declared != {23'd0, avail};
        bit0  <= usable[0];
      end

      if (cmd.load_out) begin
        if (cmd.out_full) begin
          result <= {1'b0, rate_r, ch_r[6:0], stale, tail_full[6:0], quo, chunk_begin,
                     cmd.code};
        end else begin
          result <= {116'd0, cmd.code};
        end
      end
    end
  end

endmodule

// File: rtl/wavhv_ctrl.sv
// Controller: parse state machine, input acceptance and result handshake.
module wavhv_ctrl
  import wavhv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     sof,
  input  dp_stat_t stat,
  input  logic     out_ready,
  output logic     in_ready,
  output logic     out_valid,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_WAIT, S_HEAD, S_RIFF, S_HDR, S_HCHK, S_BODY, S_FCHK,
    S_BOUND, S_AVAIL, S_FIN, S_DIV, S_EMIT, S_DONE
  } state_t;

  state_t  state, state_next;
  status_t code, code_next;
  logic    full, full_next;
  logic    valid_next;
  logic    acc;

  assign in_ready = (state == S_WAIT) || (state == S_HEAD) || (state == S_HDR)
                    || (state == S_BODY) || (state == S_DONE);
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.code     = code;
    cmd.out_full = full;
    state_next   = state;
    code_next    = code;
    full_next    = full;
    valid_next   = out_valid && !out_ready;
    if (acc && sof) begin
      cmd.start = 1'b1;
      if (stat.len_bad) begin
        code_next  = ST_SHORT;
        full_next  = 1'b0;
        state_next = S_EMIT;
      end else begin
        state_next = S_HEAD;
      end
    end else begin
      case (state)
        S_HEAD: begin
          if (acc) begin
            cmd.head_byte = 1'b1;
            if (stat.head_last) state_next = S_RIFF;
          end
        end
        S_RIFF: begin
          if (!stat.riff_ok) begin
            code_next  = ST_NOT_WAVE;
            full_next  = 1'b0;
            state_next = S_EMIT;
          end else begin
            state_next = S_BOUND;
          end
        end
        S_HDR: begin
          if (acc) begin
            cmd.hdr_byte = 1'b1;
            if (stat.hdr_last) state_next = S_HCHK;
          end
        end
        S_HCHK: begin
          cmd.hchk  = 1'b1;
          full_next = 1'b0;
          if (stat.is_data) begin
            if (!stat.format_seen) begin
              code_next  = ST_NO_FMT;
              state_next = S_EMIT;
            end else begin
              state_next = S_AVAIL;
            end
          end else if (stat.bounds_bad) begin
            code_next  = ST_BOUNDS;
            state_next = S_EMIT;
          end else if (stat.fmt_dup) begin
            code_next  = ST_BAD_FMT;
            state_next = S_EMIT;
          end else if (stat.size_zero) begin
            cmd.cnt_inc = 1'b1;
            state_next  = S_BOUND;
          end else begin
            state_next = S_BODY;
          end
        end
        S_BODY: begin
          if (acc) begin
            cmd.body_byte = 1'b1;
            if (stat.ds64_bad) begin
              code_next  = ST_BAD_RF64;
              full_next  = 1'b0;
              state_next = S_EMIT;
            end else if (stat.fchk_now) begin
              state_next = S_FCHK;
            end else if (stat.body_end) begin
              cmd.cnt_inc = 1'b1;
              state_next  = S_BOUND;
            end
          end
        end
        S_FCHK: begin
          cmd.fchk = 1'b1;
          if (stat.fmt_fail) begin
            code_next  = stat.fmt_code;
            full_next  = 1'b0;
            state_next = S_EMIT;
          end else if (stat.end_pending) begin
            cmd.cnt_inc = 1'b1;
            state_next  = S_BOUND;
          end else begin
            state_next = S_BODY;
          end
        end
        S_BOUND: begin
          if (stat.bound_bad) begin
            code_next  = ST_NO_DATA;
            full_next  = 1'b0;
            state_next = S_EMIT;
          end else begin
            cmd.hdr_init = 1'b1;
            state_next   = S_HDR;
          end
        end
        S_AVAIL: begin
          cmd.avail  = 1'b1;
          state_next = S_FIN;
        end
        S_FIN: begin
          cmd.fin    = 1'b1;
          state_next = S_DIV;
        end
        S_DIV: begin
          if (stat.div_done) begin
            code_next  = stat.frames_zero ? ST_NO_FRAMES : ST_OK;
            full_next  = 1'b1;
            state_next = S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            cmd.load_out = 1'b1;
            valid_next   = 1'b1;
            state_next   = S_DONE;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT;
      out_valid <= 1'b0;
      code      <= ST_OK;
      full      <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= valid_next;
      code      <= code_next;
      full      <= full_next;
    end
  end

endmodule

// File: rtl/wavhv_checker.sv
// Port-level checks on the WAV header validator, bound to the top level.
`include "wav_header_validator_macros.svh"

module wavhv_checker
  import wavhv_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  `WAVHV_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `WAVHV_ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `WAVHV_ASSERT_SAME(a_code_range, clk, rst, m_tvalid, m_tdata[3:0] <= ST_NO_DATA)
  `WAVHV_ASSERT_SAME(a_err_zero, clk, rst, m_tvalid && m_tdata[3:0] != ST_OK && m_tdata[3:0] != ST_NO_FRAMES, m_tdata[119:4] == '0)
  `WAVHV_ASSERT_SAME(a_ok_frames, clk, rst, m_tvalid && m_tdata[3:0] == ST_OK, m_tdata[84:45] != '0)

endmodule

bind wav_header_validator wavhv_checker u_chk (.*);
